// File: hw/rtl/msix_vector_table_access_unit_assert.svh
// assertion macros for the msix vector table access unit
`ifndef MSIX_VECTOR_TABLE_ACCESS_UNIT_ASSERT_SVH
`define MSIX_VECTOR_TABLE_ACCESS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MSIX_VTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSIX_VTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSIX_VTA_ASSERT(lbl, prop, msg)
`define MSIX_VTA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/msix_vta_pkg.sv
// shared types and constants for the msix vector table access unit
package msix_vta_pkg;

    localparam logic [6:0] NO_ENTRY = 7'd64;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_NOT_DWORD = 3'd2,
        ST_PASS      = 3'd3,
        ST_NO_DEV    = 3'd4
    } msix_vta_status_t;

    typedef enum logic [1:0] {
        CFG_ENTRIES     = 2'd0,
        CFG_TABLE_START = 2'd1,
        CFG_HAS_DEV     = 2'd2
    } msix_vta_cfg_idx_t;

    // decoded access, handed from decode to the table and the formatter
    typedef struct packed {
        msix_vta_status_t status;
        logic [7:0]       rel_idx;
        logic             word_sel;
        logic             dword_sel;
        logic             qword;
        logic             is_write;
    } msix_vta_cmd_t;

endpackage

// File: hw/rtl/msix_vta_if.sv
// request and response channel interfaces
interface msix_vta_req_if;
    logic        valid;
    logic        ready;
    logic        is_write;
    logic [11:0] access_offset;
    logic [3:0]  access_bytes;
    logic [63:0] write_data;

    modport source (output valid, is_write, access_offset, access_bytes, write_data,
                    input ready);
    modport sink (input valid, is_write, access_offset, access_bytes, write_data,
                  output ready);
endinterface

interface msix_vta_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [2:0]  status;
    logic [6:0]  entry_index;

    modport source (output valid, read_data, status, entry_index, input ready);
    modport sink (input valid, read_data, status, entry_index, output ready);
endinterface

// File: hw/rtl/msix_vta_decode.sv
// access classification: size, alignment and table window checks
module msix_vta_decode #(
    parameter int MAX_ENTRIES  = 64,
    parameter int WINDOW_BYTES = 4096
) (
    input  logic                  is_write,
    input  logic [11:0]           access_offset,
    input  logic [3:0]            access_bytes,
    input  logic [6:0]            entries_in_use,
    input  logic [11:0]           table_start,
    input  logic                  has_physical_device,
    output msix_vta_pkg::msix_vta_cmd_t cmd
);
    import msix_vta_pkg::*;

    // entries_in_use is 7 bits, so the table never exceeds 127 entries
    localparam int         CNT_MAX   = (MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES;
    localparam logic [6:0] CNT_MAX7  = 7'(CNT_MAX);
    // table end stays below 8192, so a wider window never clamps
    localparam int         WIN_MAX   = (WINDOW_BYTES > 8191) ? 8191 : WINDOW_BYTES;
    localparam logic [12:0] WIN13    = 13'(WIN_MAX);

    logic        size_ok;
    logic        align_ok;
    logic [6:0]  count;
    logic [11:0] start;
    logic [12:0] tbl_end;
    logic [12:0] tbl_end_c;
    logic        in_table;
    logic [11:0] rel;

    always_comb
    begin
        size_ok   = (access_bytes == 4'd1) || (access_bytes == 4'd2) ||
                    (access_bytes == 4'd4) || (access_bytes == 4'd8);
        align_ok  = (access_offset[3:0] & (access_bytes - 4'd1)) == 4'd0;
        count     = (entries_in_use > CNT_MAX7) ? CNT_MAX7 : entries_in_use;
        start     = {table_start[11:4], 4'b0000};
        tbl_end   = {1'b0, start} + {2'b00, count, 4'b0000};
        tbl_end_c = (tbl_end > WIN13) ? WIN13 : tbl_end;
        in_table  = (access_offset >= start) && ({1'b0, access_offset} < tbl_end_c);
        rel       = access_offset - start;

        cmd.rel_idx   = rel[11:4];
        cmd.word_sel  = rel[3];
        cmd.dword_sel = rel[2];
        cmd.qword     = access_bytes[3];
        cmd.is_write  = is_write;

        if (!size_ok || !align_ok)
        begin
            cmd.status = ST_BAD_SIZE;
        end
        else if (in_table)
        begin
            cmd.status = (access_bytes == 4'd4 || access_bytes == 4'd8) ? ST_DONE
                                                                       : ST_NOT_DWORD;
        end
        else if (has_physical_device)
        begin
            cmd.status = ST_PASS;
        end
        else
        begin
            cmd.status = ST_NO_DEV;
        end
    end

endmodule

// File: hw/rtl/msix_vta_table.sv
// vector table storage: two dword banks with per-word valid bits
module msix_vta_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  msix_vta_pkg::msix_vta_cmd_t cmd,
    input  logic [63:0]                 write_data,
    output logic [63:0]                 word
);
    import msix_vta_pkg::*;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DEPTH   = 2 * MAX_ENTRIES;
    localparam int ADDR_W  = IDX_W + 1;

    logic [31:0]       lo_mem [DEPTH];
    logic [31:0]       hi_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    logic [ADDR_W-1:0] addr;
    logic              wr;
    logic              word_valid;
    logic              lo_we;
    logic              hi_we;
    logic [31:0]       lo_wdata;
    logic [31:0]       hi_wdata;

    logic [31:0]       rd_lo_reg;
    logic [31:0]       rd_hi_reg;
    logic              rd_valid_reg;
    logic              rd_odd_reg;

    always_comb
    begin
        addr       = {IDX_W'(cmd.rel_idx), cmd.word_sel};
        wr         = en && (cmd.status == ST_DONE) && cmd.is_write;
        word_valid = valid_reg[addr];
        // a never-written word holds its reset value, so fill the untouched half with it
        lo_we      = wr && (cmd.qword || !cmd.dword_sel || !word_valid);
        hi_we      = wr && (cmd.qword || cmd.dword_sel || !word_valid);
        lo_wdata   = (cmd.qword || !cmd.dword_sel) ? write_data[31:0] : 32'd0;
        if (cmd.qword)
        begin
            hi_wdata = write_data[63:32];
        end
        else if (cmd.dword_sel)
        begin
            hi_wdata = write_data[31:0];
        end
        else
        begin
            hi_wdata = {31'd0, cmd.word_sel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
        begin
            lo_mem[addr] <= lo_wdata;
        end
        if (hi_we)
        begin
            hi_mem[addr] <= hi_wdata;
        end
        if (en)
        begin
            rd_lo_reg    <= lo_mem[addr];
            rd_hi_reg    <= hi_mem[addr];
            rd_valid_reg <= word_valid;
            rd_odd_reg   <= cmd.word_sel;
        end
    end

    // reset value: mask bit (bit 32 of the upper word of each entry)
    assign word = rd_valid_reg ? {rd_hi_reg, rd_lo_reg} : {31'd0, rd_odd_reg, 32'd0};

endmodule

// File: hw/rtl/msix_vector_table_access_unit.sv
// msix vector table access unit: input stage, decode, table read, result stage
// throughput: one access per cycle; every stage can move each cycle, rsp back-pressure stalls
// reset: config goes to one entry at offset 0 with no physical device,
// every table entry reads back with its mask bit set, all pipeline stages empty
`include "msix_vector_table_access_unit_assert.svh"

module msix_vector_table_access_unit #(
    parameter int MAX_ENTRIES  = 64,
    parameter int WINDOW_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_write_data,
    msix_vta_req_if.sink   req,
    msix_vta_rsp_if.source rsp
);
    import msix_vta_pkg::*;

    // configuration registers
    logic [6:0]  entries_reg;
    logic [11:0] table_start_reg;
    logic        has_dev_reg;

    // stage 1: captured request beat
    logic        s1_valid_reg;
    logic        s1_is_write_reg;
    logic [11:0] s1_offset_reg;
    logic [3:0]  s1_bytes_reg;
    logic [63:0] s1_wdata_reg;

    // stage 2: decoded command, table read in flight
    logic          s2_valid_reg;
    msix_vta_cmd_t s2_cmd_reg;

    // result stage
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [2:0]  out_status_reg;
    logic [6:0]  out_index_reg;
    logic [63:0] out_data_next;
    logic [6:0]  out_index_next;

    msix_vta_cmd_t s1_cmd;
    logic [63:0]   tbl_word;

    // elastic handshake: each stage moves when the one after it has room
    logic out_free;
    logic adv2;
    logic adv1;
    logic s1_free;
    logic req_acc;

    assign out_free = !out_valid_reg || rsp.ready;
    assign adv2     = s2_valid_reg && out_free;
    assign adv1     = s1_valid_reg && (!s2_valid_reg || adv2);
    assign s1_free  = !s1_valid_reg || adv1;
    assign req_acc  = req.valid && s1_free;

    assign req.ready = s1_free;

    // config writes land only while idle; the user must keep to this, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg     <= 7'd1;
            table_start_reg <= 12'd0;
            has_dev_reg     <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ENTRIES:     entries_reg     <= cfg_write_data[6:0];
                CFG_TABLE_START: table_start_reg <= cfg_write_data;
                CFG_HAS_DEV:     has_dev_reg     <= cfg_write_data[0];
                default:         ;
            endcase
        end
    end

    // valid bits for all three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= req.valid;
            end
            if (!s2_valid_reg || adv2)
            begin
                s2_valid_reg <= adv1;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_is_write_reg <= req.is_write;
            s1_offset_reg   <= req.access_offset;
            s1_bytes_reg    <= req.access_bytes;
            s1_wdata_reg    <= req.write_data;
        end
        if (adv1)
        begin
            s2_cmd_reg <= s1_cmd;
        end
        if (adv2)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= s2_cmd_reg.status;
            out_index_reg  <= out_index_next;
        end
    end

    msix_vta_decode #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_decode (
        .is_write            (s1_is_write_reg),
        .access_offset       (s1_offset_reg),
        .access_bytes        (s1_bytes_reg),
        .entries_in_use      (entries_reg),
        .table_start         (table_start_reg),
        .has_physical_device (has_dev_reg),
        .cmd                 (s1_cmd)
    );

    // table writes and reads happen as a beat leaves stage 1, so accesses stay in order
    msix_vta_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv1),
        .cmd        (s1_cmd),
        .write_data (s1_wdata_reg),
        .word       (tbl_word)
    );

    // read data formatting: dword reads come back in the low half
    always_comb
    begin
        out_data_next  = 64'd0;
        out_index_next = NO_ENTRY;
        if (s2_cmd_reg.status == ST_DONE)
        begin
            out_index_next = 7'(s2_cmd_reg.rel_idx);
            if (!s2_cmd_reg.is_write)
            begin
                if (s2_cmd_reg.qword)
                begin
                    out_data_next = tbl_word;
                end
                else if (s2_cmd_reg.dword_sel)
                begin
                    out_data_next = {32'd0, tbl_word[63:32]};
                end
                else
                begin
                    out_data_next = {32'd0, tbl_word[31:0]};
                end
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_index = out_index_reg;

    `MSIX_VTA_ASSERT(a_no_entry_off_table, !(out_valid_reg && out_status_reg != ST_DONE) || out_index_reg == NO_ENTRY, "entry index set on a non-table result")
    `MSIX_VTA_ASSERT(a_zero_data, !(out_valid_reg && out_status_reg != ST_DONE) || out_data_reg == 64'd0, "nonzero data on a rejected or outside access")
    `MSIX_VTA_ASSERT_NEXT(a_accept_fills_s1, req_acc, s1_valid_reg, "accepted beat missing from stage 1")
    `MSIX_VTA_ASSERT_NEXT(a_s1_moves_to_s2, adv1, s2_valid_reg, "beat lost between stage 1 and stage 2")

endmodule

// File: tb/msix_vector_table_access_unit_tb.sv
// self-checking testbench for the msix vector table access unit
`timescale 1ns / 1ps

module msix_vector_table_access_unit_tb;

    import msix_vta_pkg::*;

    // window geometry of the instance under test
    localparam int TABLE_SLOTS   = 64;
    localparam int WINDOW_SIZE   = 4096;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;

    // one expected reply beat
    typedef struct packed {
        logic [63:0]      data;
        msix_vta_status_t status;
        logic [6:0]       entry;
    } table_reply_t;

    logic clk;
    logic rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_write_data;

    msix_vta_req_if req_ch ();
    msix_vta_rsp_if rsp_ch ();

    msix_vector_table_access_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    // shadow of the vector table: two 64-bit words per entry
    logic [63:0]  vec_words [2 * TABLE_SLOTS];
    // shadow of the configuration registers
    logic [6:0]   entries_cfg;
    logic [11:0]  start_cfg;
    logic         dev_cfg;

    table_reply_t replies_due [$];
    int           error_count;
    int           cycles;
    // random idle bursts on the request and reply sides
    bit           gaps_on;
    bit           stalls_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // cycle counter and run-time limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, replies_due.size());
            $display("[msix_vector_table_access_unit] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        error_count++;
    endtask

    // byte span of the table in the window: low 4 bits of the start are dropped,
    // the entry count saturates, and the span is clipped at the window end
    task automatic table_bounds(output int lo, output int hi);
        int cnt;
        cnt = (entries_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(entries_cfg);
        lo = int'({start_cfg[11:4], 4'h0});
        hi = lo + cnt * 16;
        if (hi > WINDOW_SIZE)
        begin
            hi = WINDOW_SIZE;
        end
    endtask

    // works out the reply of one accepted access and applies its write
    task automatic predict_access(input logic wr, input logic [11:0] off,
                                  input logic [3:0] nbytes, input logic [63:0] wd);
        table_reply_t r;
        int lo, hi, rel, w, sz;
        logic [63:0] word;
        sz = int'(nbytes);
        r.data = '0;
        r.entry = NO_ENTRY;
        table_bounds(lo, hi);
        if (!(sz == 1 || sz == 2 || sz == 4 || sz == 8) || (int'(off) & (sz - 1)) != 0)
        begin
            // odd size, oversize or misaligned: dropped
            r.status = ST_BAD_SIZE;
        end
        else if (int'(off) >= lo && int'(off) < hi)
        begin
            if (sz < 4)
            begin
                r.status = ST_NOT_DWORD;
            end
            else
            begin
                rel = int'(off) - lo;
                w = 2 * (rel >> 4) + ((rel >> 3) & 1);
                r.status = ST_DONE;
                r.entry = 7'(rel >> 4);
                word = vec_words[w];
                if (sz == 8)
                begin
                    if (wr)
                        vec_words[w] = wd;
                    else
                        r.data = word;
                end
                else if ((rel & 4) != 0)
                begin
                    // upper dword of the word
                    if (wr)
                        vec_words[w] = {wd[31:0], word[31:0]};
                    else
                        r.data = {32'h0, word[63:32]};
                end
                else
                begin
                    if (wr)
                        vec_words[w] = {word[63:32], wd[31:0]};
                    else
                        r.data = {32'h0, word[31:0]};
                end
            end
        end
        else
        begin
            // outside the table: pass-through or read zero
            r.status = dev_cfg ? ST_PASS : ST_NO_DEV;
        end
        replies_due.push_back(r);
    endtask

    // drives one access beat and waits for it to be taken;
    // returns at the accepting edge with valid still high
    task automatic send_access(input logic wr, input logic [11:0] off,
                               input logic [3:0] nbytes, input logic [63:0] wd);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.is_write      <= wr;
        req_ch.access_offset <= off;
        req_ch.access_bytes  <= nbytes;
        req_ch.write_data    <= wd;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predict_access(wr, off, nbytes, wd);
    endtask

    // register write with the block idle: no beat in flight, all replies back
    task automatic write_reg(input msix_vta_cfg_idx_t which, input logic [11:0] value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(negedge clk);
        end
        // let the pipeline run dry past its latency
        repeat (6) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_index      <= which;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (which)
            CFG_ENTRIES:     entries_cfg = value[6:0];
            CFG_TABLE_START: start_cfg = value;
            CFG_HAS_DEV:     dev_cfg = value[0];
            default:         ;
        endcase
    endtask

    // reply checker: each accepted reply beat against the oldest expectation
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                report_mismatch("reply beat with no access outstanding");
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_ch.read_data !== want.data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              rsp_ch.read_data, want.data));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d (%s)",
                                              rsp_ch.status, want.status,
                                              want.status.name()));
                if (rsp_ch.entry_index !== want.entry)
                    report_mismatch($sformatf("entry_index %0d, want %0d",
                                              rsp_ch.entry_index, want.entry));
            end
        end
    end

    // reply side back-pressure in bursts
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // reset contents, default config, size and alignment rules
    task automatic test_reset_state();
        // entry 0 as it comes out of reset: only the mask bit set
        send_access(1'b0, 12'd0, 4'd8, '0);
        send_access(1'b0, 12'd8, 4'd8, '0);
        send_access(1'b0, 12'd12, 4'd4, '0);
        send_access(1'b0, 12'd8, 4'd4, '0);
        send_access(1'b0, 12'd4, 4'd4, '0);
        // qword write of all ones, then dword halves
        send_access(1'b1, 12'd0, 4'd8, '1);
        send_access(1'b0, 12'd0, 4'd4, '0);
        send_access(1'b0, 12'd4, 4'd4, '0);
        send_access(1'b1, 12'd4, 4'd4, 64'hFFFF_FFFF_0000_0000);
        send_access(1'b0, 12'd0, 4'd8, '0);
        // unmask entry 0
        send_access(1'b1, 12'd12, 4'd4, '0);
        send_access(1'b0, 12'd8, 4'd8, '0);
        // byte and word accesses inside the table
        send_access(1'b0, 12'd0, 4'd1, '0);
        send_access(1'b1, 12'd2, 4'd2, '1);
        // odd sizes, oversize, misalignment
        send_access(1'b0, 12'd0, 4'd0, '0);
        send_access(1'b1, 12'd0, 4'd3, '1);
        send_access(1'b0, 12'd0, 4'd15, '0);
        send_access(1'b1, 12'd0, 4'd9, '1);
        send_access(1'b0, 12'd1, 4'd2, '0);
        send_access(1'b1, 12'd2, 4'd4, '1);
        send_access(1'b1, 12'd4, 4'd8, '1);
        // outside the table with no device
        send_access(1'b0, 12'd16, 4'd4, '0);
        send_access(1'b1, 12'd4088, 4'd8, '1);
        send_access(1'b0, 12'd4095, 4'd1, '0);
    endtask

    // register extremes: full table, no table, saturation, clipped window end
    task automatic test_config_extremes();
        write_reg(CFG_ENTRIES, 12'd64);
        send_access(1'b1, 12'd1008, 4'd8, '1);
        send_access(1'b1, 12'd1020, 4'd4, '0);
        send_access(1'b0, 12'd1016, 4'd8, '0);
        send_access(1'b0, 12'd1024, 4'd4, '0);
        write_reg(CFG_HAS_DEV, 12'd1);
        send_access(1'b0, 12'd1024, 4'd4, '0);
        send_access(1'b1, 12'd4095, 4'd1, '1);
        // no table at all
        write_reg(CFG_ENTRIES, 12'd0);
        send_access(1'b0, 12'd0, 4'd8, '0);
        // count saturates, start low bits dropped, span clipped at window end
        write_reg(CFG_ENTRIES, 12'd127);
        write_reg(CFG_TABLE_START, 12'hF87);
        send_access(1'b0, 12'd4088, 4'd8, '0);
        send_access(1'b0, 12'hF7C, 4'd4, '0);
        write_reg(CFG_TABLE_START, 12'hFFF);
        send_access(1'b0, 12'd4092, 4'd4, '0);
        write_reg(CFG_HAS_DEV, 12'd0);
        send_access(1'b0, 12'd0, 4'd4, '0);
    endtask

    // one random access: mostly well-formed table traffic, some noise
    task automatic random_access();
        int kind, lo, hi, slots, sz;
        logic [11:0] off;
        logic        wr;
        kind = $urandom_range(0, 9);
        table_bounds(lo, hi);
        slots = (hi - lo) / 16;
        if (kind < 6 && slots > 0)
        begin
            sz = $urandom_range(0, 1) ? 8 : 4;
            off = 12'(lo + 16 * $urandom_range(0, slots - 1)
                      + ((sz == 8) ? 8 * $urandom_range(0, 1) : 4 * $urandom_range(0, 3)));
            wr = 1'($urandom_range(0, 1));
            send_access(wr, off, 4'(sz), {$urandom, $urandom});
            // read back what was just written
            if (wr && $urandom_range(0, 2) == 0)
                send_access(1'b0, off, 4'(sz), {$urandom, $urandom});
        end
        else if (kind < 8)
        begin
            // legal size and alignment anywhere in the window
            sz = 1 << $urandom_range(0, 3);
            off = 12'($urandom_range(0, WINDOW_SIZE - 1)) & ~12'(sz - 1);
            send_access(1'($urandom_range(0, 1)), off, 4'(sz), {$urandom, $urandom});
        end
        else
        begin
            send_access(1'($urandom_range(0, 1)), 12'($urandom_range(0, WINDOW_SIZE - 1)),
                        4'($urandom_range(0, 15)), {$urandom, $urandom});
        end
    endtask

    // phases of random traffic, each under its own register setting
    task automatic test_random_traffic();
        int pick;
        for (int phase = 0; phase < 7; phase++)
        begin
            // last phase runs at full rate on both sides
            if (phase == 6)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(CFG_ENTRIES, 12'd0);
            else if (pick == 1)
                write_reg(CFG_ENTRIES, 12'($urandom_range(65, 127)));
            else if (pick == 2)
                write_reg(CFG_ENTRIES, 12'd64);
            else
                write_reg(CFG_ENTRIES, 12'($urandom_range(1, 64)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_TABLE_START, 12'($urandom_range(0, 255)));
            else
                write_reg(CFG_TABLE_START, 12'($urandom_range(0, WINDOW_SIZE - 1)));
            write_reg(CFG_HAS_DEV, 12'($urandom_range(0, 1)));
            repeat (55) random_access();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        error_count = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        cfg_write_en = 1'b0;
        cfg_index = CFG_ENTRIES;
        cfg_write_data = '0;
        req_ch.valid = 1'b0;
        req_ch.is_write = 1'b0;
        req_ch.access_offset = '0;
        req_ch.access_bytes = '0;
        req_ch.write_data = '0;
        // shadow state as after reset
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            vec_words[2 * i] = '0;
            vec_words[2 * i + 1] = 64'h1_0000_0000;
        end
        entries_cfg = 7'd1;
        start_cfg = '0;
        dev_cfg = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_config_extremes();
        test_random_traffic();

        // drop valid after the last beat, then drain
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && replies_due.size() == 0)
            $display("[msix_vector_table_access_unit] OK");
        else
            $display("[msix_vector_table_access_unit] ERROR");
        $finish;
    end

endmodule
